/* design/aptk_pkg.sv */
// ----------------------------------------------------------------------------
// aptk_pkg
// shared types and constants of the box pair contact tracker
// ----------------------------------------------------------------------------
package aptk_pkg;

   // request field widths
   localparam int ID_W   = 6;
   localparam int POS_W  = 24;
   localparam int SIZE_W = 16;

   // widths inside the overlap test
   localparam int DIFF_W  = POS_W + 1;    // centre distance, signed
   localparam int SUM_W   = SIZE_W + 1;   // summed size factors, signed
   localparam int BOUND_W = SUM_W + 6;    // fifty times the sum, signed
   localparam int MAG_W   = BOUND_W - 1;  // magnitude of the bound

   // half extent is fifty times the raw size factor
   localparam logic signed [BOUND_W-1:0] HALF_SCALE = BOUND_W'(50);

   localparam int MAX_COLLIDERS_DEF = 64;

   typedef enum logic [1:0] {
      EVT_NONE  = 2'd0,
      EVT_ENTER = 2'd1,
      EVT_STAY  = 2'd2,
      EVT_EXIT  = 2'd3
   } contact_event_type;

   // write back of one touching bit
   typedef struct packed {
      logic en;
      logic touching;
   } touch_wr_type;

endpackage

/* design/aptk_overlap.sv */
// ----------------------------------------------------------------------------
// aptk_overlap
// axis aligned overlap test: distances and size sums registered on load,
// bounds and compares on the registered values
// ----------------------------------------------------------------------------
module aptk_overlap (
   input  logic                                clock,
   input  logic                                load,
   input  logic signed [aptk_pkg::POS_W-1:0]   left_x,
   input  logic signed [aptk_pkg::POS_W-1:0]   left_y,
   input  logic signed [aptk_pkg::POS_W-1:0]   right_x,
   input  logic signed [aptk_pkg::POS_W-1:0]   right_y,
   input  logic signed [aptk_pkg::SIZE_W-1:0]  left_w,
   input  logic signed [aptk_pkg::SIZE_W-1:0]  left_h,
   input  logic signed [aptk_pkg::SIZE_W-1:0]  right_w,
   input  logic signed [aptk_pkg::SIZE_W-1:0]  right_h,
   output logic                                overlap
);

   logic signed [aptk_pkg::DIFF_W-1:0]  dx_ff, dy_ff;
   logic signed [aptk_pkg::SUM_W-1:0]   sw_ff, sh_ff;
   logic signed [aptk_pkg::BOUND_W-1:0] bw, bh;
   logic        [aptk_pkg::DIFF_W-1:0]  adx, ady;
   logic        [aptk_pkg::MAG_W-1:0]   abw, abh;
   logic                                ov_x, ov_y;

   always_ff @(posedge clock) begin
      if (load) begin
         dx_ff <= aptk_pkg::DIFF_W'(left_x) - aptk_pkg::DIFF_W'(right_x);
         dy_ff <= aptk_pkg::DIFF_W'(left_y) - aptk_pkg::DIFF_W'(right_y);
         sw_ff <= aptk_pkg::SUM_W'(left_w) + aptk_pkg::SUM_W'(right_w);
         sh_ff <= aptk_pkg::SUM_W'(left_h) + aptk_pkg::SUM_W'(right_h);
      end
   end

   always_comb begin
      // most negative distance negates to itself, which reads right unsigned
      adx = dx_ff[aptk_pkg::DIFF_W-1] ? aptk_pkg::DIFF_W'(-dx_ff)
                                      : aptk_pkg::DIFF_W'(dx_ff);
      ady = dy_ff[aptk_pkg::DIFF_W-1] ? aptk_pkg::DIFF_W'(-dy_ff)
                                      : aptk_pkg::DIFF_W'(dy_ff);
      bw  = aptk_pkg::BOUND_W'(sw_ff) * aptk_pkg::HALF_SCALE;
      bh  = aptk_pkg::BOUND_W'(sh_ff) * aptk_pkg::HALF_SCALE;
      abw = bw[aptk_pkg::BOUND_W-1] ? aptk_pkg::MAG_W'(-bw) : aptk_pkg::MAG_W'(bw);
      abh = bh[aptk_pkg::BOUND_W-1] ? aptk_pkg::MAG_W'(-bh) : aptk_pkg::MAG_W'(bh);
      ov_x = adx < aptk_pkg::DIFF_W'(abw);
      ov_y = ady < aptk_pkg::DIFF_W'(abh);
      overlap = ov_x && ov_y;
   end

endmodule

/* design/aptk_touch_store.sv */
// ----------------------------------------------------------------------------
// aptk_touch_store
// touching bit memory: one read and one write a cycle, forwarding of the
// last write, clearing pass after reset
// ----------------------------------------------------------------------------
module aptk_touch_store #(
   parameter int ADDR_W = 12
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   rd_en,
   input  logic [ADDR_W-1:0]      rd_addr,
   input  aptk_pkg::touch_wr_type wr,
   input  logic [ADDR_W-1:0]      wr_addr,
   output logic                   touching,
   output logic                   clear_busy
);

   localparam int DEPTH = 2 ** ADDR_W;

   logic                mem [DEPTH];
   logic                rd_data_ff;
   logic [ADDR_W-1:0]   rd_addr_ff;
   logic                fwd_valid_ff;
   logic [ADDR_W-1:0]   fwd_addr_ff;
   logic                fwd_data_ff;
   logic                clear_busy_ff;
   logic [ADDR_W-1:0]   clear_cnt_ff;
   logic                mem_we;
   logic [ADDR_W-1:0]   mem_waddr;
   logic                mem_wdata;

   always_comb begin
      mem_we    = clear_busy_ff || wr.en;
      mem_waddr = clear_busy_ff ? clear_cnt_ff : wr_addr;
      mem_wdata = clear_busy_ff ? 1'b0 : wr.touching;
   end

   always_ff @(posedge clock) begin
      if (mem_we) begin
         mem[mem_waddr] <= mem_wdata;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
         rd_addr_ff <= rd_addr;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         clear_busy_ff <= 1'b1;
         clear_cnt_ff  <= '0;
      end else if (clear_busy_ff) begin
         clear_cnt_ff <= clear_cnt_ff + 1'b1;
         if (clear_cnt_ff == {ADDR_W{1'b1}}) begin
            clear_busy_ff <= 1'b0;
         end
      end
   end

   // the read at the edge of a write returns the old bit
   always_ff @(posedge clock) begin
      if (reset) begin
         fwd_valid_ff <= 1'b0;
      end else if (wr.en && !clear_busy_ff) begin
         fwd_valid_ff <= 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (wr.en) begin
         fwd_addr_ff <= wr_addr;
         fwd_data_ff <= wr.touching;
      end
   end

   assign touching   = (fwd_valid_ff && fwd_addr_ff == rd_addr_ff) ? fwd_data_ff
                                                                   : rd_data_ff;
   assign clear_busy = clear_busy_ff;

endmodule

/* design/aabb_pair_contact_tracker_core.sv */
// ----------------------------------------------------------------------------
// aabb_pair_contact_tracker_core
// box pair overlap test with enter, stay and exit tracking per ordered pair
// ----------------------------------------------------------------------------
//  channel   direction  handshake            payload
//  req       in         req_valid/req_stall  ids, centres, size factors
//  rsp       out        rsp_valid/rsp_stall  contact event, overlapping
//
//  one request a cycle sustained unless held by rsp_stall; a result is registered
//  in stage 1 and then in the result register; the pair's touching bit is read at
//  accept and written back as the request leaves stage 1; a back to back request
//  for the same pair takes the last write forwarded; after reset a clearing pass over
//  2**(2*clog2(min(MAX_COLLIDERS,64))) entries (4096 at the default) runs with req_stall high
//  under rsp_stall the result register holds and one more request is taken
// ----------------------------------------------------------------------------
module aabb_pair_contact_tracker_core #(
   parameter int MAX_COLLIDERS = aptk_pkg::MAX_COLLIDERS_DEF
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_stall,
   input  logic [aptk_pkg::ID_W-1:0]           req_left_id,
   input  logic [aptk_pkg::ID_W-1:0]           req_right_id,
   input  logic signed [aptk_pkg::POS_W-1:0]   req_left_x,
   input  logic signed [aptk_pkg::POS_W-1:0]   req_left_y,
   input  logic signed [aptk_pkg::POS_W-1:0]   req_right_x,
   input  logic signed [aptk_pkg::POS_W-1:0]   req_right_y,
   input  logic signed [aptk_pkg::SIZE_W-1:0]  req_left_w,
   input  logic signed [aptk_pkg::SIZE_W-1:0]  req_left_h,
   input  logic signed [aptk_pkg::SIZE_W-1:0]  req_right_w,
   input  logic signed [aptk_pkg::SIZE_W-1:0]  req_right_h,
   output logic                                rsp_valid,
   input  logic                                rsp_stall,
   output logic [1:0]                          rsp_contact_event,
   output logic                                rsp_overlapping
);

   // ids never reach past what their width can carry
   localparam int ID_SPAN = (MAX_COLLIDERS < 2 ** aptk_pkg::ID_W) ? MAX_COLLIDERS
                                                                   : 2 ** aptk_pkg::ID_W;
   localparam int IDX_W  = $clog2(ID_SPAN);
   localparam int ADDR_W = 2 * IDX_W;
   localparam logic [aptk_pkg::ID_W:0] ID_LIMIT = (aptk_pkg::ID_W + 1)'(ID_SPAN);

   logic                        accept;
   logic                        out_free;
   logic                        s1_adv;
   logic                        s1_valid_ff;
   logic                        s1_inrange_ff;
   logic [ADDR_W-1:0]           s1_addr_ff;
   logic [ADDR_W-1:0]           req_addr;
   logic                        req_inrange;
   logic                        ov;
   logic                        touching;
   logic                        clear_busy;
   aptk_pkg::touch_wr_type      wr;
   aptk_pkg::contact_event_type s1_event;
   logic                        rsp_valid_ff;
   aptk_pkg::contact_event_type rsp_event_ff;
   logic                        rsp_overlapping_ff;

   assign out_free  = !rsp_valid_ff || !rsp_stall;
   assign s1_adv    = s1_valid_ff && out_free;
   assign req_stall = clear_busy || (s1_valid_ff && !out_free);
   assign accept    = req_valid && !req_stall;

   assign req_addr    = {req_left_id[IDX_W-1:0], req_right_id[IDX_W-1:0]};
   assign req_inrange = ({1'b0, req_left_id} < ID_LIMIT) &&
                        ({1'b0, req_right_id} < ID_LIMIT);

   aptk_overlap u_overlap (
      .clock   (clock),
      .load    (accept),
      .left_x  (req_left_x),
      .left_y  (req_left_y),
      .right_x (req_right_x),
      .right_y (req_right_y),
      .left_w  (req_left_w),
      .left_h  (req_left_h),
      .right_w (req_right_w),
      .right_h (req_right_h),
      .overlap (ov)
   );

   aptk_touch_store #(
      .ADDR_W (ADDR_W)
   ) u_touch_store (
      .clock      (clock),
      .reset      (reset),
      .rd_en      (accept),
      .rd_addr    (req_addr),
      .wr         (wr),
      .wr_addr    (s1_addr_ff),
      .touching   (touching),
      .clear_busy (clear_busy)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else if (accept) begin
         s1_valid_ff <= 1'b1;
      end else if (s1_adv) begin
         s1_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         s1_addr_ff    <= req_addr;
         s1_inrange_ff <= req_inrange;
      end
   end

   always_comb begin
      s1_event    = aptk_pkg::EVT_NONE;
      wr.en       = 1'b0;
      wr.touching = ov;
      if (s1_inrange_ff) begin
         case ({ov, touching})
            2'b10:   s1_event = aptk_pkg::EVT_ENTER;
            2'b11:   s1_event = aptk_pkg::EVT_STAY;
            2'b01:   s1_event = aptk_pkg::EVT_EXIT;
            default: s1_event = aptk_pkg::EVT_NONE;
         endcase
         wr.en = s1_adv && (ov != touching);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (s1_adv) begin
         rsp_valid_ff <= 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (s1_adv) begin
         rsp_event_ff       <= s1_event;
         rsp_overlapping_ff <= ov;
      end
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_contact_event = rsp_event_ff;
   assign rsp_overlapping   = rsp_overlapping_ff;

`ifndef SYNTH
   a_enter_stay_overlap: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && (rsp_event_ff == aptk_pkg::EVT_ENTER ||
                       rsp_event_ff == aptk_pkg::EVT_STAY) |-> rsp_overlapping_ff)
      else $error("enter or stay reported without overlap");

   a_exit_no_overlap: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_event_ff == aptk_pkg::EVT_EXIT |-> !rsp_overlapping_ff)
      else $error("exit reported while overlapping");

   a_fwd_enter: assert property (@(posedge clock) disable iff (reset)
      (s1_adv && wr.en && ov) ##1
      (s1_adv && s1_inrange_ff && ov && s1_addr_ff == $past(s1_addr_ff))
      |-> s1_event == aptk_pkg::EVT_STAY)
      else $error("same pair after enter did not see its touching bit set");

   a_fwd_exit: assert property (@(posedge clock) disable iff (reset)
      (s1_adv && wr.en && !ov) ##1
      (s1_adv && s1_inrange_ff && !ov && s1_addr_ff == $past(s1_addr_ff))
      |-> s1_event == aptk_pkg::EVT_NONE)
      else $error("same pair after exit did not see its touching bit cleared");

   a_clear_idle: assert property (@(posedge clock) disable iff (reset)
      clear_busy |-> !s1_valid_ff && !wr.en)
      else $error("request in flight during clearing pass");
`endif

endmodule

/* verif/tb.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// checks the box pair contact tracker against its own overlap and touch map
// model: directed corner cases, back to back requests on two pairs, then
// sequences of random box pairs with and without sender gaps and receiver stalls
// ----------------------------------------------------------------------------
module tb;

   typedef struct {
      logic [aptk_pkg::ID_W-1:0]          left_id;
      logic [aptk_pkg::ID_W-1:0]          right_id;
      logic signed [aptk_pkg::POS_W-1:0]  left_x;
      logic signed [aptk_pkg::POS_W-1:0]  left_y;
      logic signed [aptk_pkg::POS_W-1:0]  right_x;
      logic signed [aptk_pkg::POS_W-1:0]  right_y;
      logic signed [aptk_pkg::SIZE_W-1:0] left_w;
      logic signed [aptk_pkg::SIZE_W-1:0] left_h;
      logic signed [aptk_pkg::SIZE_W-1:0] right_w;
      logic signed [aptk_pkg::SIZE_W-1:0] right_h;
   } box_pair_type;

   typedef struct {
      aptk_pkg::contact_event_type evt;
      logic                        ovl;
   } contact_type;

   localparam int COLLIDERS    = aptk_pkg::MAX_COLLIDERS_DEF;
   localparam int CYCLE_LIMIT  = 200000;
   localparam int SETTLE_CYCLES = 8;

   logic                               clock = 1'b0;
   logic                               reset = 1'b1;
   logic                               req_valid = 1'b0;
   logic                               req_stall;
   logic [aptk_pkg::ID_W-1:0]          req_left_id = '0;
   logic [aptk_pkg::ID_W-1:0]          req_right_id = '0;
   logic signed [aptk_pkg::POS_W-1:0]  req_left_x = '0;
   logic signed [aptk_pkg::POS_W-1:0]  req_left_y = '0;
   logic signed [aptk_pkg::POS_W-1:0]  req_right_x = '0;
   logic signed [aptk_pkg::POS_W-1:0]  req_right_y = '0;
   logic signed [aptk_pkg::SIZE_W-1:0] req_left_w = '0;
   logic signed [aptk_pkg::SIZE_W-1:0] req_left_h = '0;
   logic signed [aptk_pkg::SIZE_W-1:0] req_right_w = '0;
   logic signed [aptk_pkg::SIZE_W-1:0] req_right_h = '0;
   logic                               rsp_valid;
   logic                               rsp_stall = 1'b0;
   logic [1:0]                         rsp_contact_event;
   logic                               rsp_overlapping;

   bit          touch_map [COLLIDERS*COLLIDERS];
   contact_type expected_contacts [$];
   contact_type rsp_exp;
   int          mismatch_count = 0;
   int          cycle_count = 0;
   int          req_gap_pct = 0;
   int          rsp_stall_pct = 0;

   aabb_pair_contact_tracker_core dut (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_stall         (req_stall),
      .req_left_id       (req_left_id),
      .req_right_id      (req_right_id),
      .req_left_x        (req_left_x),
      .req_left_y        (req_left_y),
      .req_right_x       (req_right_x),
      .req_right_y       (req_right_y),
      .req_left_w        (req_left_w),
      .req_left_h        (req_left_h),
      .req_right_w       (req_right_w),
      .req_right_h       (req_right_h),
      .rsp_valid         (rsp_valid),
      .rsp_stall         (rsp_stall),
      .rsp_contact_event (rsp_contact_event),
      .rsp_overlapping   (rsp_overlapping)
   );

   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   always @(posedge clock) begin
      rsp_stall <= ($urandom_range(0, 99) < rsp_stall_pct);
   end

   always @(posedge clock) begin
      cycle_count = cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("** aabb_pair_contact_tracker_core: FAILED **");
         $finish;
      end
   end

   // strict test on one axis: |ca - cb| < |50 * (sa + sb)|
   function automatic bit axis_hit(input logic signed [aptk_pkg::POS_W-1:0] ca, cb,
                                   input logic signed [aptk_pkg::SIZE_W-1:0] sa, sb);
      longint span;
      longint reach;
      span  = longint'(ca) - longint'(cb);
      reach = 50 * (longint'(sa) + longint'(sb));
      if (span < 0) span = -span;
      if (reach < 0) reach = -reach;
      return span < reach;
   endfunction

   function automatic contact_type predict_contact(input box_pair_type p);
      contact_type c;
      int          idx;
      c.ovl = axis_hit(p.left_x, p.right_x, p.left_w, p.right_w) &&
              axis_hit(p.left_y, p.right_y, p.left_h, p.right_h);
      c.evt = aptk_pkg::EVT_NONE;
      if (p.left_id < COLLIDERS && p.right_id < COLLIDERS) begin
         idx = int'(p.left_id) * COLLIDERS + int'(p.right_id);
         if (c.ovl) begin
            if (touch_map[idx]) begin
               c.evt = aptk_pkg::EVT_STAY;
            end else begin
               c.evt = aptk_pkg::EVT_ENTER;
               touch_map[idx] = 1'b1;
            end
         end else if (touch_map[idx]) begin
            c.evt = aptk_pkg::EVT_EXIT;
            touch_map[idx] = 1'b0;
         end
      end
      return c;
   endfunction

   function automatic box_pair_type build_pair(input int l, r, lx, ly, rx, ry,
                                               input int lw, lh, rw, rh);
      box_pair_type p;
      p.left_id  = aptk_pkg::ID_W'(l);
      p.right_id = aptk_pkg::ID_W'(r);
      p.left_x   = aptk_pkg::POS_W'(lx);
      p.left_y   = aptk_pkg::POS_W'(ly);
      p.right_x  = aptk_pkg::POS_W'(rx);
      p.right_y  = aptk_pkg::POS_W'(ry);
      p.left_w   = aptk_pkg::SIZE_W'(lw);
      p.left_h   = aptk_pkg::SIZE_W'(lh);
      p.right_w  = aptk_pkg::SIZE_W'(rw);
      p.right_h  = aptk_pkg::SIZE_W'(rh);
      return p;
   endfunction

   // mostly modest sizes of either sign, now and then any 16 bit pattern
   function automatic logic signed [aptk_pkg::SIZE_W-1:0] random_size();
      int mag;
      if ($urandom_range(0, 4) == 0) return aptk_pkg::SIZE_W'($urandom);
      mag = $urandom_range(0, 2000);
      if ($urandom_range(0, 1) == 1) mag = -mag;
      return aptk_pkg::SIZE_W'(mag);
   endfunction

   // boxes placed inside or just around the reach, so the pair's bit moves
   function automatic box_pair_type random_box_pair(input int l, r, input bit near);
      box_pair_type p;
      longint       bx;
      longint       by;
      longint       dx;
      longint       dy;
      int           lx;
      int           ly;
      int           far_axis;
      p.left_id  = aptk_pkg::ID_W'(l);
      p.right_id = aptk_pkg::ID_W'(r);
      p.left_w   = random_size();
      p.left_h   = random_size();
      p.right_w  = random_size();
      p.right_h  = random_size();
      bx = 50 * (longint'(p.left_w) + longint'(p.right_w));
      by = 50 * (longint'(p.left_h) + longint'(p.right_h));
      if (bx < 0) bx = -bx;
      if (by < 0) by = -by;
      lx = int'($urandom_range(0, 8388607)) - 4194304;
      ly = int'($urandom_range(0, 8388607)) - 4194304;
      far_axis = $urandom_range(0, 2);
      if (near || far_axis == 1) dx = $urandom_range(0, int'(bx));
      else dx = bx + $urandom_range(0, 200000);
      if (near || far_axis == 0) dy = $urandom_range(0, int'(by));
      else dy = by + $urandom_range(0, 200000);
      if ($urandom_range(0, 1) == 1) dx = -dx;
      if ($urandom_range(0, 1) == 1) dy = -dy;
      p.left_x  = aptk_pkg::POS_W'(lx);
      p.left_y  = aptk_pkg::POS_W'(ly);
      p.right_x = aptk_pkg::POS_W'(longint'(lx) + dx);
      p.right_y = aptk_pkg::POS_W'(longint'(ly) + dy);
      return p;
   endfunction

   function automatic box_pair_type random_noise();
      box_pair_type p;
      p.left_id  = aptk_pkg::ID_W'($urandom);
      p.right_id = aptk_pkg::ID_W'($urandom);
      p.left_x   = aptk_pkg::POS_W'($urandom);
      p.left_y   = aptk_pkg::POS_W'($urandom);
      p.right_x  = aptk_pkg::POS_W'($urandom);
      p.right_y  = aptk_pkg::POS_W'($urandom);
      p.left_w   = aptk_pkg::SIZE_W'($urandom);
      p.left_h   = aptk_pkg::SIZE_W'($urandom);
      p.right_w  = aptk_pkg::SIZE_W'($urandom);
      p.right_h  = aptk_pkg::SIZE_W'($urandom);
      return p;
   endfunction

   task automatic send_pair(input box_pair_type p);
      while ($urandom_range(0, 99) < req_gap_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid    <= 1'b1;
      req_left_id  <= p.left_id;
      req_right_id <= p.right_id;
      req_left_x   <= p.left_x;
      req_left_y   <= p.left_y;
      req_right_x  <= p.right_x;
      req_right_y  <= p.right_y;
      req_left_w   <= p.left_w;
      req_left_h   <= p.left_h;
      req_right_w  <= p.right_w;
      req_right_h  <= p.right_h;
      do @(posedge clock); while (req_stall !== 1'b0);
      expected_contacts.push_back(predict_contact(p));
   endtask

   // sender holds off until every outstanding request has its result
   task automatic wait_all_results();
      req_valid <= 1'b0;
      @(posedge clock);
      while (expected_contacts.size() != 0) @(posedge clock);
   endtask

   always @(posedge clock) begin
      if (!reset && rsp_valid === 1'b1 && rsp_stall === 1'b0) begin
         if (expected_contacts.size() == 0) begin
            mismatch_count = mismatch_count + 1;
            if (mismatch_count <= 10)
               $display("%0t: unexpected result, contact_event %0d overlapping %0d",
                        $time, rsp_contact_event, rsp_overlapping);
         end else begin
            rsp_exp = expected_contacts.pop_front();
            if (rsp_contact_event !== rsp_exp.evt || rsp_overlapping !== rsp_exp.ovl) begin
               mismatch_count = mismatch_count + 1;
               if (mismatch_count <= 10)
                  $display("%0t: contact_event exp %0d got %0d, overlapping exp %0d got %0d",
                           $time, rsp_exp.evt, rsp_contact_event, rsp_exp.ovl,
                           rsp_overlapping);
            end
         end
      end
   end

   task automatic test_directed_cases();
      req_gap_pct   = 0;
      rsp_stall_pct = 0;
      // zero sizes give a zero reach, so never an overlap
      send_pair(build_pair(0, 0, 0, 0, 0, 0, 0, 0, 0, 0));
      // reach of 100 on both axes: enter, stay, exit at exactly the reach, enter
      send_pair(build_pair(3, 5, 1000, -2000, 1000, -2000, 1, 1, 1, 1));
      send_pair(build_pair(3, 5, 1000, -2000, 1099, -1901, 1, 1, 1, 1));
      send_pair(build_pair(3, 5, 1000, -2000, 1100, -2000, 1, 1, 1, 1));
      send_pair(build_pair(3, 5, 1000, -2000, 901, -2000, 1, 1, 1, 1));
      // the reversed pair keeps a bit of its own
      send_pair(build_pair(5, 3, 1000, -2000, 1000, -2000, 1, 1, 1, 1));
      send_pair(build_pair(3, 5, 1000, -2000, 90000, -2000, 1, 1, 1, 1));
      // same collider on both sides
      send_pair(build_pair(9, 9, 0, 0, 10, 10, 2, 2, 2, 2));
      send_pair(build_pair(9, 9, 0, 0, 10, 10, 2, 2, 2, 2));
      send_pair(build_pair(9, 9, 0, 0, 10, 400, 2, 2, 2, 2));
      // coordinate and size extremes
      send_pair(build_pair(63, 63, 8388607, 8388607, -8388608, -8388608,
                           32767, 32767, 32767, 32767));
      // negative sizes, reach 3276800
      send_pair(build_pair(63, 0, -8388608, 8388607, -5111809, 8388607,
                           -32768, -32768, -32768, -32768));
      send_pair(build_pair(63, 0, -8388608, 8388607, -5111808, 5111807,
                           -32768, -32768, -32768, -32768));
      // sizes cancel out to a zero reach
      send_pair(build_pair(0, 63, 0, 0, 0, 0, 1000, 1000, -1000, -1000));
      // mixed signs, reach 10000; then only the y axis misses
      send_pair(build_pair(1, 2, 500, 500, 10499, 500, -300, -300, 100, 100));
      send_pair(build_pair(1, 2, 500, 500, 500, 10500, -300, -300, 100, 100));
      send_pair(build_pair(62, 1, -8388608, -8388608, -8388603, -8388608, 1, 1, 0, 0));
      send_pair(build_pair(62, 1, 8388607, 8388607, 8388607, 8388607,
                           32767, -32768, 32767, -32768));
      send_pair(build_pair(42, 21, 8388607, -8388608, -8388608, 8388607, -1, -1, -1, -1));
   endtask

   // consecutive requests on the same few pairs exercise the forwarding path
   task automatic test_back_to_back_pairs();
      int n;
      req_gap_pct   = 0;
      rsp_stall_pct = 0;
      for (n = 0; n < 48; n++) begin
         send_pair(random_box_pair($urandom_range(10, 11), 12,
                                   $urandom_range(0, 99) < 60));
      end
   endtask

   task automatic test_random_traffic(input int gap_pct, stall_pct, count);
      int sent;
      int run_len;
      int l;
      int r;
      req_gap_pct   = gap_pct;
      rsp_stall_pct = stall_pct;
      sent = 0;
      while (sent < count) begin
         if ($urandom_range(0, 99) < 75) begin
            // a run of requests on one pair, drawn mostly from a small pool
            if ($urandom_range(0, 3) == 0) begin
               l = $urandom_range(0, 63);
               r = $urandom_range(0, 63);
            end else begin
               l = $urandom_range(0, 7);
               r = $urandom_range(0, 7);
            end
            run_len = $urandom_range(2, 8);
            repeat (run_len) begin
               send_pair(random_box_pair(l, r, $urandom_range(0, 99) < 65));
               sent++;
            end
         end else begin
            send_pair(random_noise());
            sent++;
         end
      end
   endtask

   initial begin
      repeat (5) @(posedge clock);
      reset <= 1'b0;
      test_directed_cases();
      wait_all_results();
      test_back_to_back_pairs();
      wait_all_results();
      test_random_traffic(10, 86, 300);
      wait_all_results();
      test_random_traffic(86, 10, 300);
      test_random_traffic(0, 0, 300);
      wait_all_results();
      repeat (SETTLE_CYCLES) @(posedge clock);
      if (mismatch_count == 0 && expected_contacts.size() == 0) begin
         $display("** aabb_pair_contact_tracker_core: PASSED **");
      end else begin
         $display("** aabb_pair_contact_tracker_core: FAILED **");
      end
      $finish;
   end

endmodule
